/* hdl/tgf_pkg.sv */
`default_nettype none

package tgf_pkg;

    localparam int OP_W      = 2;
    localparam int ELEM_W    = 10;
    localparam int TEAM_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int NUM_ELEMS = 1 << ELEM_W;
    localparam int NUM_TEAMS = 1 << TEAM_W;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [ELEM_W-1:0]   elem_t;
    typedef logic [TEAM_W-1:0]   team_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_ASSIGN  = 2'd0;
    localparam op_t OP_ENQUEUE = 2'd1;
    localparam op_t OP_DEQUEUE = 2'd2;
    localparam op_t OP_CLEAR   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the transaction and launch the first reads
        logic enq_alloc;  // take a slot and fill in its value and team
        logic link_self;  // write the next pointer of the new slot
        logic link_prev;  // link the new slot in and post the result
        logic finish;     // one-step operations: commit and post the result
    } tgf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic out_free;
    } tgf_stat_t;

endpackage

`default_nettype wire

/* hdl/tgf_ctrl.sv */
`default_nettype none

module tgf_ctrl
    import tgf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire tgf_stat_t stat,
    output tgf_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_LINK1 = 2'd2;
    localparam logic [1:0] S_LINK2 = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // A successful enqueue goes on to the link steps; everything
                // else completes here once the output register can take it.
                if (stat.op == OP_ENQUEUE && !stat.full)
                begin
                    cmd.enq_alloc = 1'b1;
                    state_next    = S_LINK1;
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LINK1:
            begin
                cmd.link_self = 1'b1;
                state_next    = S_LINK2;
            end
            S_LINK2:
            begin
                if (stat.out_free)
                begin
                    cmd.link_prev = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tgf_dpath.sv */
`default_nettype none

module tgf_dpath
    import tgf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [ELEM_W-1:0]   element,
    input  wire logic [TEAM_W-1:0]   team_id,
    input  wire tgf_cmd_t            cmd,
    output tgf_stat_t                stat,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [ELEM_W-1:0]        value,
    output logic [STATUS_W-1:0]      status
);

    localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Captured transaction.
    op_t   op_reg;
    elem_t elem_reg;
    team_t tid_reg;

    // Memories and their registered read data.
    team_t tt_mem [NUM_ELEMS];
    elem_t sv_mem [QUEUE_SLOTS];
    team_t st_mem [QUEUE_SLOTS];
    slot_t sn_mem [QUEUE_SLOTS];
    slot_t fs_mem [QUEUE_SLOTS];
    team_t tt_rdata;
    elem_t sv_rdata;
    team_t st_rdata;
    slot_t sn_rdata;
    slot_t fs_rdata;

    // Last queued slot of each team, and which teams have members waiting.
    slot_t                last_mem [NUM_TEAMS];
    logic [NUM_TEAMS-1:0] waiting_reg;

    slot_t head_reg;
    slot_t tail_reg;
    cnt_t  occ_reg;
    cnt_t  free_top_reg;
    cnt_t  fresh_reg;

    // Enqueue in flight.
    slot_t slot_reg;
    team_t team_reg;
    slot_t last_reg;
    logic  wait_reg;
    logic  empty_reg;

    logic    rsp_valid_reg;
    elem_t   value_reg;
    status_t status_reg;

    cnt_t    ft_dec;
    slot_t   alloc_slot;
    team_t   lookup_team;
    slot_t   lookup_last;
    logic    deq_empty;
    logic    full;
    logic    deq_commit;
    logic    do_clear;
    logic    out_load;
    slot_t   link_slot;
    slot_t   new_next;
    logic    sn_we;
    slot_t   sn_waddr;
    slot_t   sn_wdata;
    slot_t   sn_raddr;
    elem_t   value_next;
    status_t status_next;
    logic [CNT_W:0] slot_sum;

    assign ft_dec      = free_top_reg - CNT_W'(1);
    assign alloc_slot  = (free_top_reg != '0) ? fs_rdata : fresh_reg[SLOT_W-1:0];
    assign lookup_team = (op_reg == OP_ENQUEUE) ? tt_rdata : st_rdata;
    assign lookup_last = last_mem[lookup_team];
    assign deq_empty   = (occ_reg == '0);
    assign full        = (occ_reg == CNT_W'(QUEUE_SLOTS));
    assign deq_commit  = cmd.finish && (op_reg == OP_DEQUEUE) && !deq_empty;
    assign do_clear    = cmd.finish && (op_reg == OP_CLEAR);
    assign out_load    = cmd.finish || cmd.link_prev;
    assign link_slot   = wait_reg ? last_reg : tail_reg;
    // The new slot inherits the successor of its team's last member.
    assign new_next    = (!empty_reg && wait_reg) ? sn_rdata : '0;
    assign sn_we       = cmd.link_self || (cmd.link_prev && !empty_reg);
    assign sn_waddr    = cmd.link_self ? slot_reg : link_slot;
    assign sn_wdata    = cmd.link_self ? new_next : slot_reg;
    assign sn_raddr    = cmd.enq_alloc ? lookup_last : head_reg;
    assign slot_sum    = {1'b0, free_top_reg} + {1'b0, occ_reg};

    always_comb
    begin
        value_next  = deq_commit ? sv_rdata : '0;
        status_next = ST_OK;
        if (cmd.finish)
        begin
            case (op_reg)
                OP_ENQUEUE: status_next = ST_FULL;
                OP_DEQUEUE: status_next = deq_empty ? ST_EMPTY : ST_OK;
                default:    status_next = ST_OK;
            endcase
        end
    end

    assign stat.op       = op_reg;
    assign stat.full     = full;
    assign stat.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish && op_reg == OP_ASSIGN)
        begin
            tt_mem[elem_reg] <= tid_reg;
        end
        if (cmd.load)
        begin
            tt_rdata <= tt_mem[element];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq_alloc)
        begin
            sv_mem[alloc_slot] <= elem_reg;
            st_mem[alloc_slot] <= tt_rdata;
        end
        if (cmd.load)
        begin
            sv_rdata <= sv_mem[head_reg];
            st_rdata <= st_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sn_we)
        begin
            sn_mem[sn_waddr] <= sn_wdata;
        end
        if (cmd.load || cmd.enq_alloc)
        begin
            sn_rdata <= sn_mem[sn_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deq_commit && free_top_reg < CNT_W'(QUEUE_SLOTS))
        begin
            fs_mem[free_top_reg[SLOT_W-1:0]] <= head_reg;
        end
        if (cmd.load)
        begin
            fs_rdata <= fs_mem[ft_dec[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_prev)
        begin
            last_mem[team_reg] <= slot_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            elem_reg <= element;
            tid_reg  <= team_id;
        end
        if (cmd.enq_alloc)
        begin
            slot_reg  <= alloc_slot;
            team_reg  <= tt_rdata;
            last_reg  <= lookup_last;
            wait_reg  <= waiting_reg[tt_rdata];
            empty_reg <= deq_empty;
        end
        if (out_load)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_clear)
            begin
                waiting_reg  <= '0;
                head_reg     <= '0;
                tail_reg     <= '0;
                occ_reg      <= '0;
                free_top_reg <= '0;
                fresh_reg    <= '0;
            end
            if (cmd.enq_alloc)
            begin
                if (free_top_reg != '0)
                begin
                    free_top_reg <= ft_dec;
                end
                else
                begin
                    fresh_reg <= fresh_reg + CNT_W'(1);
                end
            end
            if (cmd.link_prev)
            begin
                if (empty_reg)
                begin
                    head_reg <= slot_reg;
                    tail_reg <= slot_reg;
                end
                else if (!wait_reg || last_reg == tail_reg)
                begin
                    tail_reg <= slot_reg;
                end
                waiting_reg[team_reg] <= 1'b1;
                occ_reg               <= occ_reg + CNT_W'(1);
            end
            if (deq_commit)
            begin
                if (lookup_last == head_reg)
                begin
                    waiting_reg[st_rdata] <= 1'b0;
                end
                occ_reg <= occ_reg - CNT_W'(1);
                if (occ_reg == CNT_W'(1))
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                else
                begin
                    head_reg <= sn_rdata;
                end
                if (free_top_reg < CNT_W'(QUEUE_SLOTS))
                begin
                    free_top_reg <= free_top_reg + CNT_W'(1);
                end
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Between transactions every slot handed out is either queued or free.
    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> slot_sum == {1'b0, fresh_reg})
        else $error("slot accounting broken");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_SLOTS))
        else $error("occupancy above capacity");

    a_empty_no_team: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> waiting_reg == '0)
        else $error("team marked waiting in an empty queue");

    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_self |-> $past(cmd.enq_alloc))
        else $error("link step without slot allocation");

endmodule

`default_nettype wire

/* hdl/team_grouped_fifo_unit.sv */
// Team queue: assign, enqueue behind own team, dequeue front, clear.
// The result is registered as the operation finishes: in the execute state for assign, clear,
// dequeue and a rejected enqueue; in S_LINK2, after S_LINK1, for an accepted enqueue, due to
// the registered memory reads and the single write port of the next-pointer memory.
// A stalled response delays the finish; a new transaction is accepted only when idle.
// Reset (async, active low) empties the queue; the team table and slot memories keep contents.
`default_nettype none

module team_grouped_fifo_unit
    import tgf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [ELEM_W-1:0]   element,
    input  wire logic [TEAM_W-1:0]   team_id,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [ELEM_W-1:0]        value,
    output logic [STATUS_W-1:0]      status
);

    tgf_cmd_t  cmd;
    tgf_stat_t stat;

    tgf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgf_dpath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .element   (element),
        .team_id   (team_id),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire
